### design/mmlm_pkg.sv
// Shared types, constants and helpers for the mixing matrix with level meters.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
package mmlm_pkg;

  localparam int MAX_INPUTS  = 8;
  localparam int MAX_OUTPUTS = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int CELLS       = MAX_INPUTS * MAX_OUTPUTS;
  localparam int CELL_AW     = $clog2(CELLS);
  localparam int ICH_W       = 3;
  localparam int OCH_W       = 3;
  localparam int CNT_W       = 4;
  localparam int GAIN_W      = 18;
  localparam int ACC_W       = 48;
  localparam int PWR_W       = 47;
  localparam int MUL_W       = 25;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int SUM_W       = 66;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 17;

  localparam logic [1:0] OP_SAMPLE     = 2'd0;
  localparam logic [1:0] OP_WRITE_CELL = 2'd1;
  localparam logic [1:0] OP_CLEAR_PEAK = 2'd2;

  localparam logic KIND_INPUT  = 1'b0;
  localparam logic KIND_OUTPUT = 1'b1;

  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ALPHA     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MASTER    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_INPUTS    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_OUTPUTS   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_RD,
    ST_MIX_MAC,
    ST_SQUARE,
    ST_SM0,
    ST_SM1,
    ST_SM2,
    ST_SM3,
    ST_IN_RPT,
    ST_OUT_T,
    ST_OUT_M0,
    ST_OUT_M1,
    ST_OUT_Y,
    ST_OUT_RPT
  } state_t;

  typedef struct packed {
    logic        en;
    logic        load;
    logic        hi;
    logic [15:0] bias;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic                     mute;
  } cell_t;

  function automatic logic [CNT_W-1:0] active_cnt(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

### design/mmlm_ifs.sv
// Valid/ready channel interfaces for item beats and result beats.
// Depends on mmlm_pkg for field widths.
`timescale 1ns / 1ps
interface mmlm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              op;
  logic [mmlm_pkg::ICH_W-1:0]              in_channel;
  logic [mmlm_pkg::OCH_W-1:0]              out_channel;
  logic signed [mmlm_pkg::SAMPLE_BITS-1:0] sample;
  logic signed [mmlm_pkg::GAIN_W-1:0]      cell_gain;
  logic                                    cell_mute;

  modport source(output valid, op, in_channel, out_channel, sample, cell_gain, cell_mute,
                 input ready);
  modport sink(input valid, op, in_channel, out_channel, sample, cell_gain, cell_mute,
               output ready);
endinterface

interface mmlm_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    kind;
  logic [mmlm_pkg::OCH_W-1:0]              channel;
  logic signed [mmlm_pkg::SAMPLE_BITS-1:0] mixed_sample;
  logic [mmlm_pkg::PWR_W-1:0]              power_level;
  logic [mmlm_pkg::PWR_W-1:0]              peak_power;
  logic                                    last;

  modport source(output valid, kind, channel, mixed_sample, power_level, peak_power, last,
                 input ready);
  modport sink(input valid, kind, channel, mixed_sample, power_level, peak_power, last,
               output ready);
endinterface

### design/mmlm_cell_store.sv
// Gain/mute matrix memory with one valid bit per cell; unwritten cells read as zero.
// Depends on mmlm_pkg.
`timescale 1ns / 1ps
module mmlm_cell_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [mmlm_pkg::CELL_AW-1:0] wr_addr,
  input  mmlm_pkg::cell_t              wr_cell,
  input  logic [mmlm_pkg::CELL_AW-1:0] rd_addr,
  output mmlm_pkg::cell_t              rd_cell
);
  mmlm_pkg::cell_t                mem [mmlm_pkg::CELLS];
  logic [mmlm_pkg::CELLS-1:0]     vld_r;
  mmlm_pkg::cell_t                rd_data_r;
  logic                           rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cell;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_cell = rd_vld_r ? rd_data_r : '0;
endmodule

### design/mmlm_mac.sv
// Shared 25x25 signed multiplier with a shift-and-add accumulator.
// Depends on mmlm_pkg.
`timescale 1ns / 1ps
module mmlm_mac (
  input  logic                                clk,
  input  logic signed [mmlm_pkg::MUL_W-1:0]   op_a,
  input  logic signed [mmlm_pkg::MUL_W-1:0]   op_b,
  input  mmlm_pkg::mac_ctl_t                  ctl,
  output logic signed [mmlm_pkg::PROD_W-1:0]  prod,
  output logic [mmlm_pkg::SUM_W-1:0]          sum_r
);
  logic [mmlm_pkg::SUM_W-1:0] base;
  logic [mmlm_pkg::SUM_W-1:0] term;
  logic [mmlm_pkg::SUM_W-1:0] sum_nxt;

  assign prod = op_a * op_b;

  always_comb begin
    base = ctl.load ? mmlm_pkg::SUM_W'(ctl.bias) : sum_r;
    term = mmlm_pkg::SUM_W'(prod);
    if (ctl.hi) begin
      term = term << 24;
    end
    sum_nxt = base + term;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sum_r <= sum_nxt;
    end
  end
endmodule

### design/mix_matrix_with_level_meters_core.sv
// Top level: sequencer, channel state, configuration registers and result register.
// Depends on mmlm_pkg, mmlm_ifs, mmlm_cell_store and mmlm_mac.
//
//   port    dir  beat
//   in_ch   in   op, in_channel, out_channel, sample, cell_gain, cell_mute
//   out_ch  out  kind, channel, mixed_sample, power_level, peak_power, last
//   cfg_*   in   write enable, register index, data
//
// A sample passes once per active output through the shared multiplier, then is squared
// and smoothed; a frame end scales, squares and smooths each active output in turn. Cell
// writes, peak clears and ignored items skip the multiplier. Reset clears the matrix at once.
// A full result register stalls the sequencer only at its report steps.
`timescale 1ns / 1ps
module mix_matrix_with_level_meters_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mmlm_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [mmlm_pkg::CFG_DW-1:0]  cfg_wdata,
  mmlm_in_if.sink                      in_ch,
  mmlm_out_if.source                   out_ch
);
  localparam int SW = mmlm_pkg::SAMPLE_BITS;
  localparam int AW = mmlm_pkg::ACC_W;
  localparam int PW = mmlm_pkg::PWR_W;
  localparam int MW = mmlm_pkg::MUL_W;

  mmlm_pkg::state_t state_r, state_nxt;

  logic [16:0]                  thr_r;
  logic [15:0]                  alpha_r;
  logic [16:0]                  master_r;
  logic [mmlm_pkg::CNT_W-1:0]   nin_cfg_r;
  logic [mmlm_pkg::CNT_W-1:0]   nout_cfg_r;
  logic [mmlm_pkg::CNT_W-1:0]   nin;
  logic [mmlm_pkg::CNT_W-1:0]   nout;

  logic signed [AW-1:0] acc_r  [mmlm_pkg::MAX_OUTPUTS];
  logic [PW-1:0]        ipow_r [mmlm_pkg::MAX_INPUTS];
  logic [PW-1:0]        opow_r [mmlm_pkg::MAX_OUTPUTS];
  logic [PW-1:0]        peak_r [mmlm_pkg::MAX_OUTPUTS];

  logic [mmlm_pkg::ICH_W-1:0]  ich_r;
  logic [mmlm_pkg::OCH_W-1:0]  j_r;
  logic signed [SW-1:0]        x_r;
  logic signed [SW-1:0]        y_r;
  logic [PW-1:0]               p_r;
  logic [33:0]                 tmag_r;
  logic                        neg_r;
  logic                        outph_r;

  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [mmlm_pkg::OCH_W-1:0]  out_chan_r;
  logic signed [SW-1:0]        out_samp_r;
  logic [PW-1:0]               out_pow_r;
  logic [PW-1:0]               out_peak_r;
  logic                        out_last_r;

  logic                        accept;
  logic                        slot_free;
  logic                        frame_end;
  logic                        j_last;
  logic                        cell_wr;
  mmlm_pkg::cell_t             wr_cell;
  mmlm_pkg::cell_t             rd_cell;
  logic [mmlm_pkg::CELL_AW-1:0] wr_addr;
  logic [mmlm_pkg::CELL_AW-1:0] rd_addr;

  logic signed [MW-1:0]              op_a, op_b;
  mmlm_pkg::mac_ctl_t                mac_ctl;
  logic signed [mmlm_pkg::PROD_W-1:0] prod;
  logic [mmlm_pkg::SUM_W-1:0]        sum_r;

  logic [PW-1:0]        lvl;
  logic [PW-1:0]        new_lvl;
  logic [PW-1:0]        new_peak;
  logic [16:0]          beta;
  logic                 mix_on;
  logic signed [AW:0]   mix_sum;
  logic signed [AW-1:0] mix_sat;
  logic signed [AW-1:0] acc_j;
  logic [AW:0]          acc_mag;
  logic [AW:0]          t_round;
  logic [51:0]          ymag;
  logic signed [SW-1:0] y_nxt;

  assign nin  = mmlm_pkg::active_cnt(nin_cfg_r, mmlm_pkg::CNT_W'(mmlm_pkg::MAX_INPUTS));
  assign nout = mmlm_pkg::active_cnt(nout_cfg_r, mmlm_pkg::CNT_W'(mmlm_pkg::MAX_OUTPUTS));

  assign in_ch.ready = (state_r == mmlm_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign frame_end   = ({1'b0, ich_r} + 4'd1) == nin;
  assign j_last      = ({1'b0, j_r} + 4'd1) == nout;

  assign cell_wr = accept && (in_ch.op == mmlm_pkg::OP_WRITE_CELL);
  assign wr_addr = {in_ch.in_channel, in_ch.out_channel};
  assign wr_cell = '{gain: in_ch.cell_gain, mute: in_ch.cell_mute};
  assign rd_addr = {ich_r, j_r};

  mmlm_cell_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cell_wr),
    .wr_addr (wr_addr),
    .wr_cell (wr_cell),
    .rd_addr (rd_addr),
    .rd_cell (rd_cell)
  );

  mmlm_mac u_mac (
    .clk   (clk),
    .op_a  (op_a),
    .op_b  (op_b),
    .ctl   (mac_ctl),
    .prod  (prod),
    .sum_r (sum_r)
  );

  always_comb begin
    lvl      = outph_r ? opow_r[j_r] : ipow_r[ich_r];
    beta     = 17'd65536 - {1'b0, alpha_r};
    new_lvl  = sum_r[PW+15:16];
    new_peak = (p_r > peak_r[j_r]) ? p_r : peak_r[j_r];
    acc_j    = acc_r[j_r];
    mix_on   = (rd_cell.gain > $signed({1'b0, thr_r})) && !rd_cell.mute;
    mix_sum  = {acc_j[AW-1], acc_j} + prod[AW:0];
    if (mix_sum[AW] != mix_sum[AW-1]) begin
      mix_sat = mix_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      mix_sat = mix_sum[AW-1:0];
    end
    acc_mag = acc_j[AW-1] ? -{acc_j[AW-1], acc_j} : {1'b0, acc_j};
    t_round = (acc_mag + (AW+1)'(8192)) >> 14;
    ymag    = sum_r[65:14];
    if (neg_r) begin
      y_nxt = (ymag >= 52'(1 << (SW-1))) ? {1'b1, {(SW-1){1'b0}}} : -SW'(ymag);
    end else begin
      y_nxt = (ymag > 52'((1 << (SW-1)) - 1)) ? {1'b0, {(SW-1){1'b1}}} : SW'(ymag);
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_a      = '0;
    op_b      = '0;
    mac_ctl   = '{en: 1'b0, load: 1'b0, hi: 1'b0, bias: 16'd0};
    unique case (state_r)
      mmlm_pkg::ST_IDLE: begin
        if (accept && in_ch.op == mmlm_pkg::OP_SAMPLE && {1'b0, in_ch.in_channel} < nin) begin
          state_nxt = mmlm_pkg::ST_MIX_RD;
        end
      end
      mmlm_pkg::ST_MIX_RD: state_nxt = mmlm_pkg::ST_MIX_MAC;
      mmlm_pkg::ST_MIX_MAC: begin
        op_a      = MW'(rd_cell.gain);
        op_b      = MW'(x_r);
        state_nxt = j_last ? mmlm_pkg::ST_SQUARE : mmlm_pkg::ST_MIX_RD;
      end
      mmlm_pkg::ST_SQUARE: begin
        op_a      = outph_r ? MW'(y_r) : MW'(x_r);
        op_b      = op_a;
        state_nxt = mmlm_pkg::ST_SM0;
      end
      mmlm_pkg::ST_SM0: begin
        op_a      = $signed({1'b0, lvl[23:0]});
        op_b      = $signed(MW'(alpha_r));
        mac_ctl   = '{en: 1'b1, load: 1'b1, hi: 1'b0, bias: 16'd32768};
        state_nxt = mmlm_pkg::ST_SM1;
      end
      mmlm_pkg::ST_SM1: begin
        op_a      = $signed(MW'(lvl[PW-1:24]));
        op_b      = $signed(MW'(alpha_r));
        mac_ctl   = '{en: 1'b1, load: 1'b0, hi: 1'b1, bias: 16'd0};
        state_nxt = mmlm_pkg::ST_SM2;
      end
      mmlm_pkg::ST_SM2: begin
        op_a      = $signed({1'b0, p_r[23:0]});
        op_b      = $signed(MW'(beta));
        mac_ctl   = '{en: 1'b1, load: 1'b0, hi: 1'b0, bias: 16'd0};
        state_nxt = mmlm_pkg::ST_SM3;
      end
      mmlm_pkg::ST_SM3: begin
        op_a      = $signed(MW'(p_r[PW-1:24]));
        op_b      = $signed(MW'(beta));
        mac_ctl   = '{en: 1'b1, load: 1'b0, hi: 1'b1, bias: 16'd0};
        state_nxt = outph_r ? mmlm_pkg::ST_OUT_RPT : mmlm_pkg::ST_IN_RPT;
      end
      mmlm_pkg::ST_IN_RPT: begin
        if (slot_free) begin
          state_nxt = frame_end ? mmlm_pkg::ST_OUT_T : mmlm_pkg::ST_IDLE;
        end
      end
      mmlm_pkg::ST_OUT_T: state_nxt = mmlm_pkg::ST_OUT_M0;
      mmlm_pkg::ST_OUT_M0: begin
        op_a      = $signed({1'b0, tmag_r[23:0]});
        op_b      = $signed(MW'(master_r));
        mac_ctl   = '{en: 1'b1, load: 1'b1, hi: 1'b0, bias: 16'd8192};
        state_nxt = mmlm_pkg::ST_OUT_M1;
      end
      mmlm_pkg::ST_OUT_M1: begin
        op_a      = $signed(MW'(tmag_r[33:24]));
        op_b      = $signed(MW'(master_r));
        mac_ctl   = '{en: 1'b1, load: 1'b0, hi: 1'b1, bias: 16'd0};
        state_nxt = mmlm_pkg::ST_OUT_Y;
      end
      mmlm_pkg::ST_OUT_Y: state_nxt = mmlm_pkg::ST_SQUARE;
      mmlm_pkg::ST_OUT_RPT: begin
        if (slot_free) begin
          state_nxt = j_last ? mmlm_pkg::ST_IDLE : mmlm_pkg::ST_OUT_T;
        end
      end
      default: state_nxt = mmlm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmlm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= 17'd16;
      alpha_r    <= 16'd62259;
      master_r   <= 17'd16384;
      nin_cfg_r  <= 4'd1;
      nout_cfg_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmlm_pkg::REG_THRESHOLD: thr_r      <= cfg_wdata;
        mmlm_pkg::REG_ALPHA:     alpha_r    <= cfg_wdata[15:0];
        mmlm_pkg::REG_MASTER:    master_r   <= cfg_wdata;
        mmlm_pkg::REG_INPUTS:    nin_cfg_r  <= cfg_wdata[3:0];
        mmlm_pkg::REG_OUTPUTS:   nout_cfg_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // channel state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mmlm_pkg::MAX_OUTPUTS; i++) begin
        acc_r[i]  <= '0;
        opow_r[i] <= '0;
        peak_r[i] <= '0;
      end
      for (int i = 0; i < mmlm_pkg::MAX_INPUTS; i++) begin
        ipow_r[i] <= '0;
      end
      j_r     <= '0;
      outph_r <= 1'b0;
    end else begin
      case (state_r)
        mmlm_pkg::ST_IDLE: begin
          j_r     <= '0;
          outph_r <= 1'b0;
          if (accept && in_ch.op == mmlm_pkg::OP_CLEAR_PEAK) begin
            for (int i = 0; i < mmlm_pkg::MAX_OUTPUTS; i++) begin
              peak_r[i] <= '0;
            end
          end
        end
        mmlm_pkg::ST_MIX_MAC: begin
          if (mix_on) begin
            acc_r[j_r] <= mix_sat;
          end
          j_r <= j_last ? '0 : j_r + 3'd1;
        end
        mmlm_pkg::ST_IN_RPT: begin
          if (slot_free) begin
            ipow_r[ich_r] <= new_lvl;
            outph_r       <= frame_end;
          end
        end
        mmlm_pkg::ST_OUT_RPT: begin
          if (slot_free) begin
            opow_r[j_r] <= new_lvl;
            peak_r[j_r] <= new_peak;
            j_r         <= j_r + 3'd1;
            if (j_last) begin
              for (int i = 0; i < mmlm_pkg::MAX_OUTPUTS; i++) begin
                acc_r[i] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ich_r <= in_ch.in_channel;
      x_r   <= in_ch.sample;
    end
    if (state_r == mmlm_pkg::ST_SQUARE) begin
      p_r <= PW'(prod);
    end
    if (state_r == mmlm_pkg::ST_OUT_T) begin
      tmag_r <= t_round[33:0];
      neg_r  <= acc_j[AW-1];
    end
    if (state_r == mmlm_pkg::ST_OUT_Y) begin
      y_r <= y_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == mmlm_pkg::ST_IN_RPT || state_r == mmlm_pkg::ST_OUT_RPT)
                 && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mmlm_pkg::ST_IN_RPT && slot_free) begin
      out_kind_r <= mmlm_pkg::KIND_INPUT;
      out_chan_r <= ich_r;
      out_samp_r <= '0;
      out_pow_r  <= new_lvl;
      out_peak_r <= '0;
      out_last_r <= !frame_end;
    end else if (state_r == mmlm_pkg::ST_OUT_RPT && slot_free) begin
      out_kind_r <= mmlm_pkg::KIND_OUTPUT;
      out_chan_r <= j_r;
      out_samp_r <= y_r;
      out_pow_r  <= new_lvl;
      out_peak_r <= new_peak;
      out_last_r <= j_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.channel      = out_chan_r;
  assign out_ch.mixed_sample = out_samp_r;
  assign out_ch.power_level  = out_pow_r;
  assign out_ch.peak_power   = out_peak_r;
  assign out_ch.last         = out_last_r;
endmodule
